// File: rtl/hrrn_pkg.sv
// Shared types and constants of the HRRN scheduler.
package hrrn_pkg;

  localparam int MAX_JOBS = 64;
  localparam int IdxW     = $clog2(MAX_JOBS);
  localparam int CntW     = $clog2(MAX_JOBS + 1);
  localparam int TimeW    = 24;
  localparam int ArrW     = 16;
  localparam int BurW     = 16;
  localparam int JobIdW   = 7;
  localparam int ProdW    = TimeW + BurW;

  typedef struct packed {
    logic [ArrW-1:0] arrive_at;
    logic [BurW-1:0] run_len;
    logic            last_job;
  } hrrn_in_t;

  typedef struct packed {
    logic [JobIdW-1:0] job_id;
    logic [TimeW-1:0]  launch_at;
    logic [TimeW-1:0]  finish_at;
    logic [TimeW-1:0]  turn_len;
    logic [TimeW-1:0]  wait_len;
    logic              overflow;
    logic              last_result;
  } hrrn_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic rd;
    logic eval;
    logic mul2;
    logic cmp;
    logic advance;
    logic jump;
    logic emit;
    logic finish;
  } hrrn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_job;
    logic scan_end;
    logic found;
    logic need_cmp;
    logic out_full;
    logic last_emit;
  } hrrn_stat_t;

endpackage

// File: rtl/hrrn_ctrl.sv
// Controller state machine of the HRRN scheduler.
module hrrn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrrn_pkg::hrrn_stat_t stat_i,
  output hrrn_pkg::hrrn_cmd_t  cmd_o
);
  import hrrn_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_ADDR   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_MUL2   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_LOAD);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.last_job) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.need_cmp) begin
          state_d = S_MUL2;
        end else if (stat_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ADDR;
        end
      end
      S_DECIDE: begin
        if (stat_i.found) begin
          state_d = S_EMIT;
        end else begin
          // nothing has arrived: jump the clock and rescan
          cmd_o.jump       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_ADDR;
        end
      end
      S_EMIT: begin
        if (!stat_i.out_full) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_emit) begin
            cmd_o.finish = 1'b1;
            state_d      = S_LOAD;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_ADDR;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/hrrn_dp.sv
// Datapath of the HRRN scheduler: job store, ratio compare, clock and result register.
module hrrn_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hrrn_pkg::hrrn_in_t   in_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output hrrn_pkg::hrrn_out_t  out_data_o,
  input  hrrn_pkg::hrrn_cmd_t  cmd_i,
  output hrrn_pkg::hrrn_stat_t stat_o
);
  import hrrn_pkg::*;

  logic [ArrW-1:0]  arr_mem [MAX_JOBS];
  logic [BurW-1:0]  bur_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0] done_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     k_q;
  logic [TimeW-1:0]    clk_q;
  logic                drop_q;
  logic [IdxW-1:0]     idx_q;
  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [ArrW-1:0]     best_arr_q;
  logic [BurW-1:0]     best_bur_q;
  logic [ArrW-1:0]     min_q;
  logic [ArrW-1:0]     rd_arr_q;
  logic [BurW-1:0]     rd_bur_q;
  logic [ProdW-1:0]    prod_a_q;
  logic [ProdW-1:0]    prod_b_q;
  logic                out_valid_q;
  hrrn_out_t           out_q;

  logic [BurW-1:0]  in_bur;
  logic             has_room;
  logic             pending;
  logic             eligible;
  logic [TimeW-1:0] mul_a;
  logic [BurW-1:0]  mul_b;
  logic [ProdW-1:0] mul_p;
  logic             better;
  logic [TimeW-1:0] comp_time;
  logic [TimeW-1:0] tat_time;
  logic [CntW-1:0]  job_num;

  assign in_bur   = (in_data_i.run_len == '0) ? BurW'(1) : in_data_i.run_len;
  assign has_room = (cnt_q < CntW'(MAX_JOBS));

  assign pending  = !done_q[idx_q];
  assign eligible = pending && (TimeW'(rd_arr_q) <= clk_q);

  // one shared multiplier: candidate wait first, then best-so-far wait
  assign mul_a = cmd_i.mul2 ? (clk_q - TimeW'(best_arr_q)) : (clk_q - TimeW'(rd_arr_q));
  assign mul_b = cmd_i.mul2 ? rd_bur_q : best_bur_q;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  assign better = (prod_a_q > prod_b_q) ||
                  ((prod_a_q == prod_b_q) &&
                   ((rd_bur_q < best_bur_q) ||
                    ((rd_bur_q == best_bur_q) && (rd_arr_q < best_arr_q))));

  assign comp_time = clk_q + TimeW'(best_bur_q);
  assign tat_time  = comp_time - TimeW'(best_arr_q);
  assign job_num   = CntW'(best_idx_q) + CntW'(1);

  assign stat_o.last_job  = in_data_i.last_job;
  assign stat_o.scan_end  = (CntW'(idx_q) == (cnt_q - CntW'(1)));
  assign stat_o.found     = found_q;
  assign stat_o.need_cmp  = eligible && found_q;
  assign stat_o.out_full  = out_valid_q && out_stall_i;
  assign stat_o.last_emit = ((k_q + CntW'(1)) == cnt_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      arr_mem[cnt_q[IdxW-1:0]] <= in_data_i.arrive_at;
      bur_mem[cnt_q[IdxW-1:0]] <= in_bur;
    end
    if (cmd_i.rd) begin
      rd_arr_q <= arr_mem[idx_q];
      rd_bur_q <= bur_mem[idx_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      prod_a_q <= mul_p;
      if (eligible && !found_q) begin
        best_idx_q <= idx_q;
        best_arr_q <= rd_arr_q;
        best_bur_q <= rd_bur_q;
      end
    end
    if (cmd_i.mul2) begin
      prod_b_q <= mul_p;
    end
    if (cmd_i.cmp && better) begin
      best_idx_q <= idx_q;
      best_arr_q <= rd_arr_q;
      best_bur_q <= rd_bur_q;
    end
    if (cmd_i.scan_start) begin
      min_q <= '1;
    end else if (cmd_i.eval && pending && (rd_arr_q < min_q)) begin
      min_q <= rd_arr_q;
    end
    if (cmd_i.emit) begin
      out_q.job_id      <= JobIdW'(job_num);
      out_q.launch_at   <= clk_q;
      out_q.finish_at   <= comp_time;
      out_q.turn_len    <= tat_time;
      out_q.wait_len    <= tat_time - TimeW'(best_bur_q);
      out_q.overflow    <= drop_q;
      out_q.last_result <= stat_o.last_emit;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      clk_q       <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (has_room) begin
          cnt_q <= cnt_q + CntW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end

      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.advance) begin
          idx_q <= idx_q + IdxW'(1);
        end
        if (cmd_i.eval && eligible) begin
          found_q <= 1'b1;
        end
      end

      if (cmd_i.jump) begin
        clk_q <= TimeW'(min_q);
      end

      if (cmd_i.emit) begin
        done_q[best_idx_q] <= 1'b1;
        clk_q              <= comp_time;
        k_q                <= k_q + CntW'(1);
        out_valid_q        <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // drop the finished set back to its reset values
      if (cmd_i.finish) begin
        done_q <= '0;
        cnt_q  <= '0;
        k_q    <= '0;
        clk_q  <= '0;
        drop_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/hrrn_scheduler_unit.sv
// Top level of the HRRN scheduler: controller plus datapath.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one job request
// per cycle while the block is loading: arrival time, burst time (0 counts
// as 1) and a last-job flag. Jobs are numbered 1 upward in load order; loads
// beyond MAX_JOBS are dropped and reported through the overflow bit.
// A request with last_job set starts a non-preemptive HRRN schedule over the
// stored set; in_stall_o stays high until the last result is registered.
// Output channel (out_valid_o / out_stall_i / out_data_o) gives one result
// request per job in run order, last_result marking the final one.
// Each decision scans the n stored jobs through the job memory; an entry
// compared against the best so far uses the one shared multiplier twice,
// then the block decides and registers the result. A decision with nothing
// arrived adds one more full scan after the clock jumps.
// A stalled result holds in the output register; the scan waits only when
// a new result is ready and the register is still held. After the last
// result the block accepts the next set at once.
// Reset empties the job set, clears the clock and drops any pending result.
module hrrn_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrrn_pkg::hrrn_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrrn_pkg::hrrn_out_t out_data_o
);
  import hrrn_pkg::*;

  hrrn_cmd_t  cmd;
  hrrn_stat_t stat;

  hrrn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hrrn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// File: tb/hrrn_checker.sv
`timescale 1ns / 100ps
// Scoreboard of the HRRN scheduler: job-set prediction and result comparison.
module hrrn_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  hrrn_pkg::hrrn_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  hrrn_pkg::hrrn_out_t out_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  import hrrn_pkg::*;

  logic [ArrW-1:0] job_arrival [MAX_JOBS];
  logic [BurW-1:0] job_burst   [MAX_JOBS];
  int              jobs_held   = 0;
  logic            set_dropped = 1'b0;
  hrrn_out_t       dispatch_q [$];

  // Exact ratio compare by cross multiplication, then burst, arrival, id.
  function automatic logic outranks(int a, int b, int unsigned now);
    longint unsigned lag_a, lag_b, lhs, rhs;
    lag_a = now - job_arrival[a];
    lag_b = now - job_arrival[b];
    lhs   = lag_a * job_burst[b];
    rhs   = lag_b * job_burst[a];
    if (lhs != rhs) return lhs > rhs;
    if (job_burst[a] != job_burst[b]) return job_burst[a] < job_burst[b];
    if (job_arrival[a] != job_arrival[b]) return job_arrival[a] < job_arrival[b];
    return a < b;
  endfunction

  task automatic run_hrrn_schedule();
    logic        finished [MAX_JOBS];
    int unsigned now, next_due;
    int          pick, emitted;
    logic        found;
    hrrn_out_t   res;
    for (int i = 0; i < MAX_JOBS; i++) finished[i] = 1'b0;
    now     = 0;
    emitted = 0;
    while (emitted < jobs_held) begin
      found = 1'b0;
      pick  = 0;
      for (int i = 0; i < jobs_held; i++) begin
        if (!finished[i] && job_arrival[i] <= now) begin
          if (!found || outranks(i, pick, now)) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        // Nothing has arrived: jump to the earliest pending arrival.
        next_due = '1;
        for (int i = 0; i < jobs_held; i++)
          if (!finished[i] && job_arrival[i] < next_due) next_due = job_arrival[i];
        now = next_due;
      end else begin
        res.job_id      = JobIdW'(pick + 1);
        res.launch_at   = TimeW'(now);
        now             = now + job_burst[pick];
        res.finish_at   = TimeW'(now);
        res.turn_len    = TimeW'(now - job_arrival[pick]);
        res.wait_len    = TimeW'(now - job_arrival[pick] - job_burst[pick]);
        res.overflow    = set_dropped;
        res.last_result = (emitted + 1 == jobs_held);
        dispatch_q.push_back(res);
        finished[pick] = 1'b1;
        emitted++;
      end
    end
  endtask

  task automatic take_job(hrrn_in_t job);
    logic [BurW-1:0] burst;
    burst = (job.run_len == '0) ? BurW'(1) : job.run_len;
    if (jobs_held < MAX_JOBS) begin
      job_arrival[jobs_held] = job.arrive_at;
      job_burst[jobs_held]   = burst;
      jobs_held++;
    end else begin
      set_dropped = 1'b1;
    end
    if (job.last_job) begin
      run_hrrn_schedule();
      jobs_held   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_result(hrrn_out_t got);
    hrrn_out_t  want;
    logic [6:0] bad;
    if (dispatch_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: result with nothing expected: id=%0d start=%0d comp=%0d",
                 $time, got.job_id, got.launch_at, got.finish_at);
    end else begin
      want = dispatch_q.pop_front();
      bad  = {got.job_id !== want.job_id,
              got.launch_at !== want.launch_at,
              got.finish_at !== want.finish_at,
              got.turn_len !== want.turn_len,
              got.wait_len !== want.wait_len,
              got.overflow !== want.overflow,
              got.last_result !== want.last_result};
      if (bad != '0) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("%0t: result mismatch, field mask %b", $time, bad);
          $display("  expected id=%0d start=%0d comp=%0d tat=%0d wt=%0d ovf=%b last=%b",
                   want.job_id, want.launch_at, want.finish_at,
                   want.turn_len, want.wait_len, want.overflow, want.last_result);
          $display("  actual   id=%0d start=%0d comp=%0d tat=%0d wt=%0d ovf=%b last=%b",
                   got.job_id, got.launch_at, got.finish_at,
                   got.turn_len, got.wait_len, got.overflow, got.last_result);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_held    = 0;
      set_dropped  = 1'b0;
      dispatch_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) check_result(out_data_i);
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) take_job(in_data_i);
    end
    pending_o = dispatch_q.size();
  end

endmodule

// File: tb/tb_hrrn_scheduler_unit.sv
`timescale 1ns / 100ps
// Top of the HRRN scheduler testbench: clock, reset, job stimulus and verdict.
module tb_hrrn_scheduler_unit;
  import hrrn_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  hrrn_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  hrrn_out_t   out_data_o;
  int          pending;
  int          fail_count;
  int unsigned cycle_count = 0;
  logic        steady_mode = 1'b0;

  hrrn_scheduler_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  hrrn_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady_mode && ($urandom_range(99) < 33);
  end

  // Hold the request until it is taken; start and end on a falling edge.
  task automatic send_job(logic [ArrW-1:0] arr, logic [BurW-1:0] bur, logic last);
    while (!steady_mode && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.arrive_at <= arr;
    in_data_i.run_len   <= bur;
    in_data_i.last_job  <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Compact sets crowd arrivals and bursts to force contention and ties.
  task automatic send_set(int loads, logic compact);
    logic [ArrW-1:0] arr;
    logic [BurW-1:0] bur;
    for (int k = 0; k < loads; k++) begin
      if (compact) begin
        arr = $urandom_range(0, 3 * loads + 6);
        bur = $urandom_range(0, 12);
      end else begin
        arr = $urandom_range(0, 65535);
        bur = $urandom_range(0, 65535);
      end
      send_job(arr, bur, k == loads - 1);
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero burst alone, then a lone job that forces a clock jump
    send_job(16'd0, 16'd0, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    // equal ratios: split by burst, then arrival, then id
    send_job(16'd2, 16'd4, 1'b0);
    send_job(16'd0, 16'd4, 1'b0);
    send_job(16'd0, 16'd4, 1'b0);
    send_job(16'd1, 16'd2, 1'b0);
    send_job(16'd3, 16'd4, 1'b1);
    // ratio contest, then an idle gap before a late arrival
    send_job(16'd0, 16'd10, 1'b0);
    send_job(16'd1, 16'd2, 1'b0);
    send_job(16'd2, 16'd8, 1'b0);
    send_job(16'd3, 16'd1, 1'b0);
    send_job(16'd50, 16'd3, 1'b1);
    // toggle every field bit
    send_job(16'hAAAA, 16'h5555, 1'b0);
    send_job(16'h5555, 16'hAAAA, 1'b0);
    send_job(16'hFFFF, 16'h0001, 1'b0);
    send_job(16'h0000, 16'hFFFF, 1'b1);

    for (int s = 0; s < 16; s++) begin
      if (s == 5) begin
        // full store with no idling on either side until its results drain
        steady_mode = 1'b1;
        send_set(MAX_JOBS, 1'b1);
        in_valid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        steady_mode = 1'b0;
      end else if (s == 11) begin
        // overrun the store; the last-flagged load itself is dropped
        send_set(MAX_JOBS + 3, $urandom_range(1));
      end else begin
        send_set($urandom_range(1, 8), $urandom_range(99) < 70);
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
